>>> hdl/v3mu_pkg.sv
package v3mu_pkg;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_MUL       = 4'd2,
        OP_DIV       = 4'd3,
        OP_DOT       = 4'd4,
        OP_CROSS     = 4'd5,
        OP_SQMAG     = 4'd6,
        OP_MAG       = 4'd7,
        OP_NORM      = 4'd8,
        OP_NEG       = 4'd9,
        OP_SCALE     = 4'd10,
        OP_DIVSCALAR = 4'd11,
        OP_EQUAL     = 4'd12
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_DZ  = 2'd2
    } t_status;

    typedef struct packed {
        logic       valid;
        t_opcode    op;
        logic       eq;
        logic       ovf;
        logic [2:0] neg;
    } t_ctl;

endpackage

>>> hdl/v3mu_front.sv
module v3mu_front #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [3:0]              i_opcode,
    input  logic [2:0][DW-1:0]      i_a,
    input  logic [2:0][DW-1:0]      i_b,
    output v3mu_pkg::t_ctl          o_ctl,
    output logic [2:0][DW-1:0]      o_res,
    output logic [DW-1:0]           o_scal,
    output logic [2:0][DW-1:0]      o_num,
    output logic [2:0][DW-1:0]      o_den,
    output logic [2*DW-1:0]         o_sumsq
);
    import v3mu_pkg::*;

    localparam int PW = 2 * DW;
    localparam int SW = 2 * DW + 2;
    localparam logic signed [SW-1:0] S_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [DW-1:0] abs_f(input logic signed [DW-1:0] v);
        logic [DW-1:0] n;
        n = DW'(-v);
        return v[DW-1] ? n : v;
    endfunction

    function automatic logic signed [SW-1:0] tshr(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        m = v[SW-1] ? -v : v;
        m = m >> FB;
        return v[SW-1] ? $signed(-m) : $signed(m);
    endfunction

    function automatic logic [DW:0] sat_f(input logic signed [SW-1:0] v);
        logic [DW:0] r;
        if (v > S_MAX) begin
            r = {1'b1, D_MAX};
        end else if (v < S_MIN) begin
            r = {1'b1, D_MIN};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

    t_opcode                 w_op;
    logic signed [DW-1:0]    w_a [3];
    logic signed [DW-1:0]    w_b [3];
    logic signed [DW-1:0]    w_x [3];
    logic signed [DW-1:0]    w_y [3];

    t_ctl                    n_a_ctl, r_a_ctl;
    logic signed [PW-1:0]    n_p [3];
    logic signed [PW-1:0]    r_p [3];
    logic signed [PW-1:0]    n_q [3];
    logic signed [PW-1:0]    r_q [3];
    logic signed [DW:0]      n_e [3];
    logic signed [DW:0]      r_e [3];
    logic [2:0][DW-1:0]      n_num, r_num, n_den, r_den;

    t_ctl                    n_b_ctl, r_b_ctl;
    logic [2:0][DW-1:0]      n_res, r_res;
    logic [DW-1:0]           n_scal, r_scal;
    logic [2:0][DW-1:0]      r_b_num, r_b_den;
    logic [PW-1:0]           n_sumsq, r_sumsq;

    assign w_op = t_opcode'(i_opcode);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = $signed(i_a[i]);
            w_b[i] = $signed(i_b[i]);
        end
    end

    always_comb begin
        logic eq_all;
        eq_all = 1'b1;
        n_a_ctl = '0;
        n_a_ctl.valid = i_start;
        n_a_ctl.op = w_op;
        for (int i = 0; i < 3; i++) begin
            unique case (w_op)
                OP_CROSS: begin
                    w_x[i] = w_a[(i+1)%3];
                    w_y[i] = w_b[(i+2)%3];
                end
                OP_SCALE: begin
                    w_x[i] = w_a[i];
                    w_y[i] = w_b[0];
                end
                OP_SQMAG, OP_MAG, OP_NORM: begin
                    w_x[i] = w_a[i];
                    w_y[i] = w_a[i];
                end
                default: begin
                    w_x[i] = w_a[i];
                    w_y[i] = w_b[i];
                end
            endcase
            n_p[i] = PW'(w_x[i]) * PW'(w_y[i]);
            n_q[i] = PW'(w_a[(i+2)%3]) * PW'(w_b[(i+1)%3]);
            unique case (w_op)
                OP_ADD:  n_e[i] = (DW+1)'(w_a[i]) + (DW+1)'(w_b[i]);
                OP_SUB:  n_e[i] = (DW+1)'(w_a[i]) - (DW+1)'(w_b[i]);
                default: n_e[i] = -((DW+1)'(w_a[i]));
            endcase
            n_num[i] = abs_f(w_a[i]);
            n_den[i] = (w_op == OP_DIV) ? abs_f(w_b[i]) : abs_f(w_b[0]);
            unique case (w_op)
                OP_DIV:       n_a_ctl.neg[i] = w_a[i][DW-1] ^ w_b[i][DW-1];
                OP_DIVSCALAR: n_a_ctl.neg[i] = w_a[i][DW-1] ^ w_b[0][DW-1];
                OP_NORM:      n_a_ctl.neg[i] = w_a[i][DW-1];
                default:      n_a_ctl.neg[i] = 1'b0;
            endcase
            if (w_a[i] != w_b[i]) begin
                eq_all = 1'b0;
            end
        end
        n_a_ctl.eq = (w_op == OP_EQUAL) && eq_all;
    end

    always_comb begin
        logic signed [SW-1:0] sum3;
        logic signed [SW-1:0] v;
        logic [DW:0]          s;
        sum3 = SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]);
        n_b_ctl = r_a_ctl;
        n_b_ctl.ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            unique case (r_a_ctl.op)
                OP_ADD, OP_SUB, OP_NEG: v = SW'(r_e[i]);
                OP_MUL, OP_SCALE:       v = tshr(SW'(r_p[i]));
                OP_CROSS:               v = tshr(SW'(r_p[i]) - SW'(r_q[i]));
                default:                v = '0;
            endcase
            s = sat_f(v);
            n_res[i] = s[DW-1:0];
            n_b_ctl.ovf = n_b_ctl.ovf | s[DW];
        end
        unique case (r_a_ctl.op)
            OP_DOT, OP_SQMAG: v = tshr(sum3);
            default:          v = '0;
        endcase
        s = sat_f(v);
        n_scal = s[DW-1:0];
        n_b_ctl.ovf = n_b_ctl.ovf | s[DW];
        n_sumsq = sum3[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
            r_b_ctl.valid <= 1'b0;
        end else begin
            r_a_ctl <= n_a_ctl;
            r_b_ctl <= n_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p[i] <= n_p[i];
            r_q[i] <= n_q[i];
            r_e[i] <= n_e[i];
        end
        r_num   <= n_num;
        r_den   <= n_den;
        r_res   <= n_res;
        r_scal  <= n_scal;
        r_b_num <= r_num;
        r_b_den <= r_den;
        r_sumsq <= n_sumsq;
    end

    assign o_ctl   = r_b_ctl;
    assign o_res   = r_res;
    assign o_scal  = r_scal;
    assign o_num   = r_b_num;
    assign o_den   = r_b_den;
    assign o_sumsq = r_sumsq;

endmodule

>>> hdl/v3mu_sqrt_cell.sv
module v3mu_sqrt_cell #(
    parameter int DW  = 32,
    parameter int BIT = 0
) (
    input  logic                i_clk,
    input  logic [2*DW-1:0]     i_d,
    input  logic [DW-1:0]       i_root,
    output logic [2*DW-1:0]     o_d,
    output logic [DW-1:0]       o_root
);
    localparam int QW = 2 * DW;

    logic [QW-1:0] w_t;
    logic [QW-1:0] n_d, r_d;
    logic [DW-1:0] n_root, r_root;

    always_comb begin
        w_t = (QW'(i_root) << (BIT + 1)) + (QW'(1) << (2 * BIT));
        if (i_d >= w_t) begin
            n_d = i_d - w_t;
            n_root = i_root | (DW'(1) << BIT);
        end else begin
            n_d = i_d;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_root <= n_root;
    end

    assign o_d    = r_d;
    assign o_root = r_root;

endmodule

>>> hdl/v3mu_div_cell.sv
module v3mu_div_cell #(
    parameter int DW = 32,
    parameter int NW = 48
) (
    input  logic            i_clk,
    input  logic [DW:0]     i_rem,
    input  logic [NW-1:0]   i_n,
    input  logic [NW-1:0]   i_q,
    input  logic [DW-1:0]   i_den,
    output logic [DW:0]     o_rem,
    output logic [NW-1:0]   o_n,
    output logic [NW-1:0]   o_q,
    output logic [DW-1:0]   o_den
);
    logic [DW:0]   w_t;
    logic [DW:0]   n_rem, r_rem;
    logic [NW-1:0] n_q, r_q, r_n;
    logic [DW-1:0] r_den;

    always_comb begin
        w_t = {i_rem[DW-1:0], i_n[NW-1]};
        if (w_t >= {1'b0, i_den}) begin
            n_rem = w_t - {1'b0, i_den};
            n_q = {i_q[NW-2:0], 1'b1};
        end else begin
            n_rem = w_t;
            n_q = {i_q[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_n   <= {i_n[NW-2:0], 1'b0};
        r_den <= i_den;
    end

    assign o_rem = r_rem;
    assign o_n   = r_n;
    assign o_q   = r_q;
    assign o_den = r_den;

endmodule

>>> hdl/vector3_math_unit_core.sv
// Channel   Handshake            Payload
// input     start, busy          i_opcode, i_a_x..i_a_z, i_b_x..i_b_z
// result    o_valid (strobe)     o_r_x..o_r_z, o_scalar_out, o_equal_flag, o_status
//
// One transfer is taken every cycle; busy is always low.
// Each result passes through the front-end registers, then the row of square-root cells
// (one per root bit), then the row of restoring divider cells (one per quotient bit,
// three lanes), then the output register.
// Reset clears the valid bits of the pipeline; results in flight are dropped.
// The receiver cannot stall, so the pipeline never stops.
module vector3_math_unit_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [3:0]              i_opcode,
    input  logic [DATA_WIDTH-1:0]   i_a_x,
    input  logic [DATA_WIDTH-1:0]   i_a_y,
    input  logic [DATA_WIDTH-1:0]   i_a_z,
    input  logic [DATA_WIDTH-1:0]   i_b_x,
    input  logic [DATA_WIDTH-1:0]   i_b_y,
    input  logic [DATA_WIDTH-1:0]   i_b_z,
    output logic                    o_valid,
    output logic [DATA_WIDTH-1:0]   o_r_x,
    output logic [DATA_WIDTH-1:0]   o_r_y,
    output logic [DATA_WIDTH-1:0]   o_r_z,
    output logic [DATA_WIDTH-1:0]   o_scalar_out,
    output logic                    o_equal_flag,
    output logic [1:0]              o_status
);
    import v3mu_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int NW  = DATA_WIDTH + FRAC_BITS;
    localparam int QW  = 2 * DATA_WIDTH;
    localparam int LAT = 2 * DATA_WIDTH + FRAC_BITS + 3;
    localparam logic [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [NW-1:0] Q_LIM = NW'(1) << (DW - 1);
    localparam logic [NW-1:0] Q_MAX = Q_LIM - NW'(1);

    typedef struct packed {
        t_ctl               ctl;
        logic [2:0][DW-1:0] res;
        logic [DW-1:0]      scal;
        logic [2:0][DW-1:0] num;
        logic [2:0][DW-1:0] den;
    } t_sctx;

    typedef struct packed {
        t_ctl               ctl;
        logic [2:0]         numz;
        logic [2:0][DW-1:0] res;
        logic [DW-1:0]      scal;
    } t_dctx;

    t_ctl               f_ctl;
    logic [2:0][DW-1:0] f_res, f_num, f_den;
    logic [DW-1:0]      f_scal;
    logic [QW-1:0]      f_sumsq;

    logic [QW-1:0]      w_d    [DW+1];
    logic [DW-1:0]      w_root [DW+1];
    t_sctx              w_sctx [DW+1];
    t_sctx              r_sctx [DW];

    logic [2:0][DW:0]   w_rem  [NW+1];
    logic [2:0][NW-1:0] w_n    [NW+1];
    logic [2:0][NW-1:0] w_q    [NW+1];
    logic [2:0][DW-1:0] w_den  [NW+1];
    t_dctx              w_dctx [NW+1];
    t_dctx              r_dctx [NW];

    logic               r_out_valid;
    t_opcode            r_out_op;
    logic [2:0][DW-1:0] n_out_res, r_out_res;
    logic [DW-1:0]      r_out_scal;
    logic               r_out_eq;
    t_status            n_out_status, r_out_status;

    assign busy = 1'b0;

    v3mu_front #(
        .DW (DW),
        .FB (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_a      ({i_a_z, i_a_y, i_a_x}),
        .i_b      ({i_b_z, i_b_y, i_b_x}),
        .o_ctl    (f_ctl),
        .o_res    (f_res),
        .o_scal   (f_scal),
        .o_num    (f_num),
        .o_den    (f_den),
        .o_sumsq  (f_sumsq)
    );

    assign w_d[0]         = f_sumsq;
    assign w_root[0]      = '0;
    assign w_sctx[0].ctl  = f_ctl;
    assign w_sctx[0].res  = f_res;
    assign w_sctx[0].scal = f_scal;
    assign w_sctx[0].num  = f_num;
    assign w_sctx[0].den  = f_den;

    for (genvar k = 0; k < DW; k++) begin : g_sqrt
        v3mu_sqrt_cell #(
            .DW  (DW),
            .BIT (DW - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_d    (w_d[k]),
            .i_root (w_root[k]),
            .o_d    (w_d[k+1]),
            .o_root (w_root[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sctx[k].ctl.valid <= 1'b0;
            end else begin
                r_sctx[k] <= w_sctx[k];
            end
        end

        assign w_sctx[k+1] = r_sctx[k];
    end

    always_comb begin
        w_dctx[0].ctl  = w_sctx[DW].ctl;
        w_dctx[0].res  = w_sctx[DW].res;
        w_dctx[0].scal = w_sctx[DW].scal;
        if (w_sctx[DW].ctl.op == OP_MAG) begin
            w_dctx[0].scal = w_root[DW][DW-1] ? D_MAX : w_root[DW];
            w_dctx[0].ctl.ovf = w_sctx[DW].ctl.ovf | w_root[DW][DW-1];
        end
        for (int i = 0; i < 3; i++) begin
            w_dctx[0].numz[i] = (w_sctx[DW].num[i] == '0);
            w_rem[0][i] = '0;
            w_q[0][i]   = '0;
            w_n[0][i]   = {w_sctx[DW].num[i], {FRAC_BITS{1'b0}}};
            w_den[0][i] = (w_sctx[DW].ctl.op == OP_NORM) ? w_root[DW] : w_sctx[DW].den[i];
        end
    end

    for (genvar j = 0; j < NW; j++) begin : g_div
        for (genvar l = 0; l < 3; l++) begin : g_lane
            v3mu_div_cell #(
                .DW (DW),
                .NW (NW)
            ) u_cell (
                .i_clk (i_clk),
                .i_rem (w_rem[j][l]),
                .i_n   (w_n[j][l]),
                .i_q   (w_q[j][l]),
                .i_den (w_den[j][l]),
                .o_rem (w_rem[j+1][l]),
                .o_n   (w_n[j+1][l]),
                .o_q   (w_q[j+1][l]),
                .o_den (w_den[j+1][l])
            );
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dctx[j].ctl.valid <= 1'b0;
            end else begin
                r_dctx[j] <= w_dctx[j];
            end
        end

        assign w_dctx[j+1] = r_dctx[j];
    end

    always_comb begin
        logic          dz;
        logic          ovf;
        logic          is_div;
        logic [NW-1:0] q;
        logic [NW-1:0] nq;
        dz = 1'b0;
        ovf = w_dctx[NW].ctl.ovf;
        n_out_res = w_dctx[NW].res;
        is_div = (w_dctx[NW].ctl.op == OP_DIV) || (w_dctx[NW].ctl.op == OP_DIVSCALAR)
              || (w_dctx[NW].ctl.op == OP_NORM);
        for (int i = 0; i < 3; i++) begin
            q = w_q[NW][i];
            nq = -q;
            if (is_div) begin
                if (w_den[NW][i] == '0) begin
                    dz = 1'b1;
                    if (w_dctx[NW].numz[i]) begin
                        n_out_res[i] = '0;
                    end else begin
                        n_out_res[i] = w_dctx[NW].ctl.neg[i] ? D_MIN : D_MAX;
                    end
                end else if (w_dctx[NW].ctl.neg[i] && (q != '0)) begin
                    if (q > Q_LIM) begin
                        ovf = 1'b1;
                        n_out_res[i] = D_MIN;
                    end else begin
                        n_out_res[i] = nq[DW-1:0];
                    end
                end else begin
                    if (q > Q_MAX) begin
                        ovf = 1'b1;
                        n_out_res[i] = D_MAX;
                    end else begin
                        n_out_res[i] = q[DW-1:0];
                    end
                end
            end
        end
        if (dz) begin
            n_out_status = ST_DZ;
        end else if (ovf) begin
            n_out_status = ST_OVF;
        end else begin
            n_out_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_dctx[NW].ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_op     <= w_dctx[NW].ctl.op;
        r_out_res    <= n_out_res;
        r_out_scal   <= w_dctx[NW].scal;
        r_out_eq     <= w_dctx[NW].ctl.eq;
        r_out_status <= n_out_status;
    end

    assign o_valid      = r_out_valid;
    assign o_r_x        = r_out_res[0];
    assign o_r_y        = r_out_res[1];
    assign o_r_z        = r_out_res[2];
    assign o_scalar_out = r_out_scal;
    assign o_equal_flag = r_out_eq;
    assign o_status     = r_out_status;

    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("Result strobe without a matching input transfer.");

    a_dz_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_out_status == ST_DZ)) |->
            ((r_out_op == OP_DIV) || (r_out_op == OP_DIVSCALAR) || (r_out_op == OP_NORM)))
        else $error("Divide-by-zero status on an operation without division.");

    a_eq_only_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_equal_flag) |-> (r_out_op == OP_EQUAL))
        else $error("Equality flag set on an operation other than compare.");

endmodule
